>>> hdl/smcp_pkg.sv
// ----------------------------------------------------------------------------
// Serial motor command parser package
// Shared constants and small helpers for the command line parser.
// ----------------------------------------------------------------------------
package smcp_pkg;

  // Line storage and group layout.
  localparam int LINE_BUFFER_BYTES = 128;
  localparam int GROUP_CHARS       = 5;
  localparam int GROUP_COUNT       = 4;
  localparam int GROUP_STRIDE      = 5;
  localparam int SPEED_LINE_LENGTH = 21;

  localparam int LEN_W    = $clog2(LINE_BUFFER_BYTES);
  localparam int SPEED_W  = 16;
  localparam int BYTE_W   = 8;

  // Last position that still takes a byte into the line.
  localparam logic [LEN_W-1:0] LAST_POS = LEN_W'(LINE_BUFFER_BYTES - 2);
  localparam logic [LEN_W-1:0] FULL_LEN = LEN_W'(LINE_BUFFER_BYTES - 1);
  localparam logic [LEN_W-1:0] SPEED_CR_POS = LEN_W'(SPEED_LINE_LENGTH - 1);

  // Character codes.
  localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [BYTE_W-1:0] CHAR_E     = 8'h65;
  localparam logic [BYTE_W-1:0] CHAR_F     = 8'h66;
  localparam logic [BYTE_W-1:0] CHAR_B     = 8'h62;
  localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;

  typedef logic [SPEED_W-1:0] speed_t;

  function automatic logic is_digit(input logic [BYTE_W-1:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  // Value times ten plus a digit, wrapping at the speed width.
  function automatic speed_t mac10(input speed_t v, input logic [BYTE_W-1:0] c);
    speed_t d;
    d = SPEED_W'(c - CHAR_ZERO) & speed_t'(4'hF);
    return (v << 3) + (v << 1) + d;
  endfunction

endpackage

>>> hdl/serial_motor_command_parser.sv
// ----------------------------------------------------------------------------
// Serial motor command parser
// Collects received bytes into a command line, echoes them, and decodes
// speed lines, emergency stop and light toggles on the fly.
// ----------------------------------------------------------------------------
// Usage: each received serial byte enters as one word on the in_ channel
// (in_valid / in_stall). For every accepted byte exactly one result word
// leaves on the out_ channel (out_valid / out_stall): the echo, the four
// speeds when a 21-byte line just ended, the emergency stop flag and the
// current light levels.
// A byte accepted at a clock edge has its result word registered at that
// edge and visible in the following cycle. Throughput is one byte per
// cycle without output stalls; the line state and the result register both
// update in the accepting cycle, the group parse being one multiply-by-ten
// per group. When the receiver stalls the result word holds, and a new byte
// is taken only in a cycle where the result register is empty or being
// taken, so input stall follows output stall combinationally.
// Synchronous reset clears the line length, the group state, both lights and
// the result valid; no byte is accepted while reset is held.
// ----------------------------------------------------------------------------
module serial_motor_command_parser (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [smcp_pkg::BYTE_W-1:0]      in_rx_byte,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_echo_valid,
  output logic [smcp_pkg::BYTE_W-1:0]      out_echo_byte,
  output logic                             out_speeds_valid,
  output logic signed [smcp_pkg::SPEED_W-1:0] out_speed_first,
  output logic signed [smcp_pkg::SPEED_W-1:0] out_speed_second,
  output logic signed [smcp_pkg::SPEED_W-1:0] out_speed_third,
  output logic signed [smcp_pkg::SPEED_W-1:0] out_speed_fourth,
  output logic                             out_emergency_stop,
  output logic                             out_front_light_on,
  output logic                             out_back_light_on
);

  localparam int GC = smcp_pkg::GROUP_COUNT;

  // Line state.
  logic [smcp_pkg::LEN_W-1:0]  line_len_r, line_len_nxt;
  logic [smcp_pkg::BYTE_W-1:0] first_char_r, first_char_nxt;
  smcp_pkg::speed_t            grp_val_r [GC];
  smcp_pkg::speed_t            grp_val_nxt [GC];
  logic [GC-1:0]               grp_neg_r, grp_neg_nxt;
  logic [GC-1:0]               grp_stop_r, grp_stop_nxt;
  logic                        front_light_r, front_light_nxt;
  logic                        back_light_r, back_light_nxt;

  // Result register.
  logic                        out_valid_r;
  logic                        echo_valid_r, echo_valid_nxt;
  logic [smcp_pkg::BYTE_W-1:0] echo_byte_r, echo_byte_nxt;
  logic                        speeds_valid_r, speeds_valid_nxt;
  smcp_pkg::speed_t            speed_r [GC];
  smcp_pkg::speed_t            speed_nxt [GC];
  logic                        estop_r, estop_nxt;

  logic in_accept;
  logic out_accept;
  logic take;
  logic is_cr;
  logic digit;

  assign out_accept = out_valid_r && !out_stall;
  assign in_stall   = !rst_n || (out_valid_r && out_stall);
  assign in_accept  = in_valid && !in_stall;
  assign take       = line_len_r <= smcp_pkg::LAST_POS;
  assign is_cr      = in_rx_byte == smcp_pkg::CHAR_CR;
  assign digit      = smcp_pkg::is_digit(in_rx_byte);

  always_comb begin
    line_len_nxt     = line_len_r;
    first_char_nxt   = first_char_r;
    grp_neg_nxt      = grp_neg_r;
    grp_stop_nxt     = grp_stop_r;
    front_light_nxt  = front_light_r;
    back_light_nxt   = back_light_r;
    echo_valid_nxt   = 1'b0;
    echo_byte_nxt    = '0;
    speeds_valid_nxt = 1'b0;
    estop_nxt        = 1'b0;
    for (int g = 0; g < GC; g++) begin
      grp_val_nxt[g] = grp_val_r[g];
      speed_nxt[g]   = '0;
    end

    if (take) begin
      echo_valid_nxt = 1'b1;
      echo_byte_nxt  = in_rx_byte;
      line_len_nxt   = line_len_r + 1'b1;
      if (line_len_r == '0) begin
        first_char_nxt = in_rx_byte;
      end

      // Each group watches its own window of line positions.
      for (int g = 0; g < GC; g++) begin
        if ((int'(line_len_r) >= g * smcp_pkg::GROUP_STRIDE) &&
            (int'(line_len_r) < g * smcp_pkg::GROUP_STRIDE + smcp_pkg::GROUP_CHARS)) begin
          if (int'(line_len_r) == g * smcp_pkg::GROUP_STRIDE) begin
            grp_val_nxt[g]  = '0;
            grp_neg_nxt[g]  = 1'b0;
            grp_stop_nxt[g] = 1'b0;
            if (in_rx_byte == smcp_pkg::CHAR_MINUS) begin
              grp_neg_nxt[g] = 1'b1;
            end else if (digit) begin
              grp_val_nxt[g] = smcp_pkg::mac10('0, in_rx_byte);
            end else begin
              grp_stop_nxt[g] = 1'b1;
            end
          end else if (!grp_stop_r[g]) begin
            if (digit) begin
              grp_val_nxt[g] = smcp_pkg::mac10(grp_val_r[g], in_rx_byte);
            end else begin
              grp_stop_nxt[g] = 1'b1;
            end
          end
        end
      end

      if (is_cr) begin
        if (line_len_r == smcp_pkg::SPEED_CR_POS) begin
          speeds_valid_nxt = 1'b1;
          for (int g = 0; g < GC; g++) begin
            speed_nxt[g] = grp_neg_nxt[g] ? ('0 - grp_val_nxt[g]) : grp_val_nxt[g];
          end
        end
        estop_nxt = first_char_nxt == smcp_pkg::CHAR_E;
        if (first_char_nxt == smcp_pkg::CHAR_F) begin
          front_light_nxt = !front_light_r;
        end
        if (first_char_nxt == smcp_pkg::CHAR_B) begin
          back_light_nxt = !back_light_r;
        end
        line_len_nxt = '0;
      end
    end else begin
      // Overflow: the byte is dropped and the line starts over.
      line_len_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_len_r    <= '0;
      first_char_r  <= '0;
      grp_neg_r     <= '0;
      grp_stop_r    <= '0;
      front_light_r <= 1'b0;
      back_light_r  <= 1'b0;
      out_valid_r   <= 1'b0;
      for (int g = 0; g < GC; g++) begin
        grp_val_r[g] <= '0;
      end
    end else begin
      if (in_accept) begin
        line_len_r    <= line_len_nxt;
        first_char_r  <= first_char_nxt;
        grp_neg_r     <= grp_neg_nxt;
        grp_stop_r    <= grp_stop_nxt;
        front_light_r <= front_light_nxt;
        back_light_r  <= back_light_nxt;
        for (int g = 0; g < GC; g++) begin
          grp_val_r[g] <= grp_val_nxt[g];
        end
        out_valid_r <= 1'b1;
      end else if (out_accept) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst_n && in_accept) begin
      echo_valid_r   <= echo_valid_nxt;
      echo_byte_r    <= echo_byte_nxt;
      speeds_valid_r <= speeds_valid_nxt;
      estop_r        <= estop_nxt;
      for (int g = 0; g < GC; g++) begin
        speed_r[g] <= speed_nxt[g];
      end
    end
  end

  // The light outputs follow the light state, which changes only with a new word.
  assign out_valid          = out_valid_r;
  assign out_echo_valid     = echo_valid_r;
  assign out_echo_byte      = echo_byte_r;
  assign out_speeds_valid   = speeds_valid_r;
  assign out_speed_first    = speed_r[0];
  assign out_speed_second   = speed_r[1];
  assign out_speed_third    = speed_r[2];
  assign out_speed_fourth   = speed_r[3];
  assign out_emergency_stop = estop_r;
  assign out_front_light_on = front_light_r;
  assign out_back_light_on  = back_light_r;

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    line_len_r <= smcp_pkg::FULL_LEN)
    else $error("line length beyond buffer");

  a_speeds_cr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && speeds_valid_r |->
      echo_valid_r && (echo_byte_r == smcp_pkg::CHAR_CR))
    else $error("speeds without a carriage return");

  a_estop_cr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && estop_r |-> echo_valid_r && (echo_byte_r == smcp_pkg::CHAR_CR))
    else $error("emergency stop without a carriage return");

  a_front_toggle: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$stable(front_light_r) |->
      $past(in_accept) && $past(is_cr))
    else $error("front light changed without a line end");

  a_back_toggle: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$stable(back_light_r) |->
      $past(in_accept) && $past(is_cr))
    else $error("back light changed without a line end");

endmodule
